>>> rtl/esort_pkg.sv
// ----------------------------------------------------------------------------
// esort_pkg
// Shared widths, capacity default and sequencer states of the sort engine.
// ----------------------------------------------------------------------------
package esort_pkg;

  localparam int unsigned WordW          = 32;
  localparam int unsigned MaxItemsDefault = 64;

  typedef enum logic [2:0] {
    S_LOAD,   // collecting words of a list
    S_RDI,    // fetch word at position i
    S_LDI,    // latch word i, fetch word 0
    S_CMP,    // compare/swap against position j
    S_WBI,    // write back position i, fetch next i
    S_ERD,    // fetch first sorted word
    S_EOUT    // stream sorted words out
  } state_t;

endpackage

>>> rtl/esort_in_if.sv
// ----------------------------------------------------------------------------
// esort_in_if
// Input channel: one list element per word, last flag closes the list.
// ----------------------------------------------------------------------------
interface esort_in_if import esort_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] value;
  logic                    last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

>>> rtl/esort_out_if.sv
// ----------------------------------------------------------------------------
// esort_out_if
// Output channel: sorted elements with last and overflow flags.
// ----------------------------------------------------------------------------
interface esort_out_if import esort_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] value_res;
  logic                    last_res;
  logic                    overflow;

  modport source (output valid, value_res, last_res, overflow, input ready);
  modport sink   (input valid, value_res, last_res, overflow, output ready);
endinterface

>>> rtl/esort_mem.sv
// ----------------------------------------------------------------------------
// esort_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module esort_mem import esort_pkg::*; #(
  parameter int unsigned Depth = MaxItemsDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AddrW-1:0]        waddr,
  input  logic signed [WordW-1:0] wdata,
  input  logic                    re,
  input  logic [AddrW-1:0]        raddr,
  output logic signed [WordW-1:0] rdata
);

  logic signed [WordW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/exchange_sort_engine_core.sv
// ----------------------------------------------------------------------------
// exchange_sort_engine_core
// Collects a list of signed words, exchange-sorts it in place in the element
// store, then streams it out ascending.
// ----------------------------------------------------------------------------
// Load: one word per cycle, ready held high while collecting.
// Sort of n >= 2 words: each position i from 1 to n-1 is compared against every
//   earlier position, one compare per cycle through the single read port of the store.
// Output: S_ERD fetches the first sorted word and S_EOUT loads it into the output register, then one
//   word per cycle while results are taken.
// Reset (synchronous, rst high) clears the sequencer, count, overflow and output valid;
// the store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module exchange_sort_engine_core import esort_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDefault
) (
  input  logic        clk,
  input  logic        rst,
  esort_in_if.sink    items,
  esort_out_if.source results
);

  localparam int unsigned AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW  = $clog2(MaxItems + 1);

  // sequencer registers
  state_t                  state, state_next;
  logic [CntW-1:0]         count, count_next;   // words stored in this list
  logic                    ovf, ovf_next;       // a word of this list dropped
  logic [AddrW-1:0]        idx_i, idx_i_next;   // outer position
  logic [AddrW-1:0]        idx_j, idx_j_next;   // inner position
  logic [AddrW-1:0]        idx_k, idx_k_next;   // output position
  logic signed [WordW-1:0] cur, cur_next;       // running value of position i

  // output register
  logic                    out_valid, out_valid_next;
  logic signed [WordW-1:0] out_value, out_value_next;
  logic                    out_last, out_last_next;
  logic                    out_ovf, out_ovf_next;

  // store ports
  logic                    we, re;
  logic [AddrW-1:0]        waddr, raddr;
  logic signed [WordW-1:0] wdata, rdata;

  logic                    in_fire;
  logic                    slot_free;
  logic                    room;
  logic [CntW-1:0]         cnt_after;

  esort_mem #(
    .Depth (MaxItems),
    .AddrW (AddrW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign items.ready       = (state == S_LOAD);
  assign in_fire           = items.valid && items.ready;
  assign room              = (count < CntW'(MaxItems));
  assign cnt_after         = room ? count + CntW'(1) : count;
  // output slot may be loaded when empty or being drained this cycle
  assign slot_free         = !out_valid || results.ready;

  assign results.valid     = out_valid;
  assign results.value_res = out_value;
  assign results.last_res  = out_last;
  assign results.overflow  = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_i     <= idx_i_next;
    idx_j     <= idx_j_next;
    idx_k     <= idx_k_next;
    cur       <= cur_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
    out_ovf   <= out_ovf_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    idx_i_next     = idx_i;
    idx_j_next     = idx_j;
    idx_k_next     = idx_k;
    cur_next       = cur;
    out_valid_next = out_valid && !results.ready;
    out_value_next = out_value;
    out_last_next  = out_last;
    out_ovf_next   = out_ovf;
    we             = 1'b0;
    waddr          = count[AddrW-1:0];
    wdata          = items.value;
    re             = 1'b0;
    raddr          = idx_i;

    unique case (state)
      S_LOAD: begin
        if (in_fire) begin
          // store if there is room, else mark the list as overflowed
          we         = room;
          count_next = cnt_after;
          ovf_next   = ovf || !room;
          idx_i_next = AddrW'(1);
          idx_k_next = '0;
          if (items.last) begin
            // a single word needs no sorting
            state_next = (cnt_after == CntW'(1)) ? S_ERD : S_RDI;
          end
        end
      end

      S_RDI: begin
        re         = 1'b1;
        raddr      = idx_i;
        state_next = S_LDI;
      end

      S_LDI: begin
        // word i arrives; start the inner pass at position 0
        cur_next   = rdata;
        re         = 1'b1;
        raddr      = '0;
        idx_j_next = '0;
        state_next = S_CMP;
      end

      S_CMP: begin
        // rdata holds position j; swap when position i is smaller
        if (cur < rdata) begin
          we       = 1'b1;
          waddr    = idx_j;
          wdata    = cur;
          cur_next = rdata;
        end
        if (idx_j + AddrW'(1) != idx_i) begin
          re         = 1'b1;
          raddr      = idx_j + AddrW'(1);
          idx_j_next = idx_j + AddrW'(1);
        end else begin
          state_next = S_WBI;
        end
      end

      S_WBI: begin
        we    = 1'b1;
        waddr = idx_i;
        wdata = cur;
        if (CntW'(idx_i) + CntW'(1) < count) begin
          // fetch of i+1 overlaps the write of i (different entries)
          re         = 1'b1;
          raddr      = idx_i + AddrW'(1);
          idx_i_next = idx_i + AddrW'(1);
          state_next = S_LDI;
        end else begin
          state_next = S_ERD;
        end
      end

      S_ERD: begin
        re         = 1'b1;
        raddr      = idx_k;
        state_next = S_EOUT;
      end

      S_EOUT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_value_next = rdata;
          out_last_next  = (CntW'(idx_k) + CntW'(1) == count);
          out_ovf_next   = ovf;
          if (CntW'(idx_k) + CntW'(1) == count) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            re         = 1'b1;
            raddr      = idx_k + AddrW'(1);
            idx_k_next = idx_k + AddrW'(1);
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxItems))
    else $error("element count above capacity");

  // overflow is only flagged once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> count == CntW'(MaxItems))
    else $error("overflow flagged with room left");

  // inner position always below outer position during compares
  a_j_below_i: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> idx_j < idx_i)
    else $error("inner index reached outer index");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> $stable(out_value) && out_valid)
    else $error("pending result overwritten");

  // sorting only starts with at least two words
  a_sort_min: assert property (@(posedge clk) disable iff (rst)
    state == S_RDI |-> count >= CntW'(2))
    else $error("sort started on fewer than two words");

endmodule

>>> test/exchange_sort_engine_core_tb.sv
// ----------------------------------------------------------------------------
// exchange_sort_engine_core_tb
// Feeds lists of signed words to the sort engine and checks every sorted
// word, its last flag and its overflow flag against an in-bench sort of the
// same list. Covers extreme values, duplicates, single-word lists, full and
// overflowing lists, long output stalls and random idling on both channels.
// ----------------------------------------------------------------------------
module exchange_sort_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esort_pkg::*;

  localparam int unsigned MAX_ITEMS    = MaxItemsDefault;
  localparam int          RANDOM_WORDS = 12;
  localparam int          HOLD_CYCLES  = 800;    // long receiver stall
  localparam int          FLUSH_LIMIT  = 20000;  // cycles to wait for stragglers
  localparam int          DRAIN_CYCLES = 200;    // quiet time after last word

  typedef logic signed [WordW-1:0] word_t;

  // one sorted word as it should appear on the result channel
  typedef struct packed {
    word_t value;
    logic  last;
    logic  overflow;
  } sorted_word_t;

  localparam word_t WORD_MIN = {1'b1, {(WordW-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(WordW-1){1'b1}}};

  logic clk;
  logic rst;

  esort_in_if  in_ch ();
  esort_out_if out_ch ();

  exchange_sort_engine_core #(
    .MaxItems (MAX_ITEMS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  // --------------------------------------------------------------------------
  // Bench-side copy of the list being collected and the sorted words it owes
  // --------------------------------------------------------------------------
  word_t        list_store [MAX_ITEMS];
  int unsigned  list_count;
  bit           list_dropped;
  sorted_word_t pending_sorted [$];

  int unsigned  err_count;
  int           words_sent;
  bit           no_idle;     // set for the final stretch: no gaps either side
  bit           hold_req;    // sender asks the receiver for one long stall

  initial begin
    list_count   = 0;
    list_dropped = 0;
    err_count    = 0;
    words_sent   = 0;
    no_idle      = 0;
    hold_req     = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Take one accepted word. Words past capacity are dropped but still mark
  // the list; a last flag (dropped or not) sorts and queues the whole list.
  function automatic void collect_and_sort(input word_t v, input logic is_last);
    word_t       tmp;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    if (list_count < MAX_ITEMS) begin
      list_store[list_count] = v;
      list_count++;
    end else begin
      list_dropped = 1'b1;
    end
    if (is_last) begin
      n = list_count;
      // exchange sort: each later slot against every earlier one
      for (i = 1; i < n; i++) begin
        for (j = 0; j < i; j++) begin
          if (list_store[i] < list_store[j]) begin
            tmp           = list_store[j];
            list_store[j] = list_store[i];
            list_store[i] = tmp;
          end
        end
      end
      for (k = 0; k < n; k++) begin
        pending_sorted.push_back('{value: list_store[k], last: (k + 1 == n),
                                   overflow: list_dropped});
      end
      list_count   = 0;
      list_dropped = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock (the one reset at the start is driven by the test sequence)
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. Results are checked
  // before the input word of the same edge is folded in; a result can never
  // stem from a word accepted at that very edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sorted_word_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_sorted.size() == 0) begin
          report_mismatch($sformatf("unexpected word value %0d last %0b overflow %0b",
                                    out_ch.value_res, out_ch.last_res, out_ch.overflow));
        end else begin
          want = pending_sorted.pop_front();
          if (out_ch.value_res !== want.value)
            report_mismatch($sformatf("value_res got %0d want %0d",
                                      out_ch.value_res, want.value));
          if (out_ch.last_res !== want.last)
            report_mismatch($sformatf("last_res got %0b want %0b (value %0d)",
                                      out_ch.last_res, want.last, want.value));
          if (out_ch.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b (value %0d)",
                                      out_ch.overflow, want.overflow, want.value));
        end
      end
      if (in_ch.valid && in_ch.ready)
        collect_and_sort(in_ch.value, in_ch.last);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready in random bursts. A hold request from the sender gets one
  // long stall, counted here, so the engine fills and blocks its input.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one word and hold it until the handshake, then maybe idle.
  // valid is only lowered when a gap follows, so it never toggles in a step.
  // --------------------------------------------------------------------------
  task automatic send_word(input word_t v, input logic is_last);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // random content, biased toward extremes and a narrow band for duplicates
  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return word_t'(int'($urandom_range(0, 8)) - 4);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_list(input int n);
    int k;
    for (k = 0; k < n; k++)
      send_word(pick_value(), k == n - 1);
  endtask

  // park the input, let the monitor fold in the last handshake, then wait for
  // every owed word, bounded by FLUSH_LIMIT
  task automatic wait_all_sorted();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted.size() != 0 && waited < FLUSH_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // extremes, alternating bit patterns, single-word lists, duplicates
  task automatic test_directed();
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b1);
    send_word(-5, 1'b1);          // single-word list
    send_word(WORD_MIN, 1'b1);    // single-word list at the bottom
    send_word(7, 1'b0);           // equal values stay put
    send_word(-7, 1'b0);
    send_word(7, 1'b0);
    send_word(7, 1'b1);
    send_word(3, 1'b0);           // strictly descending
    send_word(2, 1'b0);
    send_word(1, 1'b0);
    send_word(0, 1'b1);
  endtask

  // short random lists
  task automatic test_random_lists();
    int start;
    int sel;
    int len;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      sel = $urandom_range(0, 19);
      if (sel < 16) len = $urandom_range(1, 4);
      else          len = $urandom_range(5, 8);
      send_list(len);
    end
  endtask

  // exactly full, then past capacity with a dropped word and a dropped last
  task automatic test_capacity();
    send_list(MAX_ITEMS);
    send_list(MAX_ITEMS + 2);
  endtask

  // idle engine, then a long receiver stall while the sender offers two lists
  task automatic test_backpressure();
    wait_all_sorted();
    hold_req = 1'b1;
    send_list(6);
    send_list(4);
  endtask

  // sender pauses until the engine has delivered everything owed
  task automatic test_drain_pause();
    send_list(3);
    wait_all_sorted();
    send_list(2);
  endtask

  // back-to-back lists with no gaps on either side
  task automatic test_streaming();
    int k;
    no_idle = 1'b1;
    for (k = 0; k < 3; k++)
      send_list($urandom_range(1, 4));
  endtask

  initial begin
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_lists();
    test_capacity();
    test_backpressure();
    test_drain_pause();
    test_streaming();

    wait_all_sorted();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch($sformatf("%0d sorted words never arrived", pending_sorted.size()));

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
